// ===== src/b64se_pkg.sv =====
package b64se_pkg;

    // One group of three bytes gives this many characters
    localparam int unsigned QUARTET_LEN = 4;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;   // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;   // '/'
    localparam logic [7:0] UPPER_BASE = 8'h41;   // 'A'
    localparam logic [7:0] LOWER_BASE = 8'h61;   // 'a'
    localparam logic [7:0] DIGIT_BASE = 8'h30;   // '0'

    localparam logic [1:0] LAST_SLOT = 2'd3;

    localparam logic [19:0] LIMIT_RESET = 20'hFFFFF;

    // Four finished characters plus the flags they carry
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            msg_end;
        logic            ovf;
    } b64se_quartet_t;

    // Map a 6-bit code to its character of the standard alphabet
    function automatic logic [7:0] b64se_char(input logic [5:0] code);
        logic [7:0] wide;
        wide = {2'b00, code};
        priority if (code < 6'd26)
            return UPPER_BASE + wide;
        else if (code < 6'd52)
            return LOWER_BASE + wide - 8'd26;
        else if (code < 6'd62)
            return DIGIT_BASE + wide - 8'd52;
        else if (code == 6'd62)
            return PLUS_CHAR;
        else
            return SLASH_CHAR;
    endfunction

endpackage

// ===== src/base64_stream_encoder_top.sv =====
// Base64 stream encoder (standard alphabet, '=' padding). Message bytes enter
// through push/full, one per cycle while the quartet queue has room; the last
// byte carries last_byte. Each completed group (three bytes, or a short group
// closed by last_byte) becomes one quartet of four characters, which leave
// through empty/pop at one character per cycle while empty is low and pop is
// high. A quartet is written into the queue, then loaded into the character
// register that drives the result ports. The single character port sets the
// sustained rate. QUEUE_DEPTH quartets buffer between the byte side and the
// character side. output_limit may be written only while the block is idle;
// once a quartet makes the count plus four exceed it, that quartet is flagged
// overflow and ends the message, and the remaining bytes up to and including
// the last one give no characters.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        run_last,
    output logic        message_end,
    output logic        overflow,
    input  logic        output_limit_we,
    input  logic [19:0] output_limit_wdata
);
    import b64se_pkg::*;

    b64se_quartet_t wr_quartet;
    b64se_quartet_t rd_quartet;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;

    b64se_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .full               (full),
        .output_limit_we    (output_limit_we),
        .output_limit_wdata (output_limit_wdata),
        .q_push             (q_push),
        .q_data             (wr_quartet),
        .q_full             (q_full)
    );

    b64se_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_quartet),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_quartet),
        .valid   (q_valid)
    );

    b64se_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (rd_quartet),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end),
        .overflow    (overflow)
    );

endmodule

// ===== src/b64se_front.sv =====
module b64se_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output logic                     full,
    input  logic                     output_limit_we,
    input  logic [19:0]              output_limit_wdata,
    output logic                     q_push,
    output b64se_pkg::b64se_quartet_t q_data,
    input  logic                     q_full
);
    import b64se_pkg::*;

    logic [19:0] limit_reg;
    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [20:0] chars_written_reg, chars_written_next;
    logic        dropping_reg, dropping_next;

    logic        accept;
    logic        emit;
    logic [7:0]  b0, b1, b2;
    logic [20:0] cw_sum;
    logic        ovf;

    // Stall input while the quartet queue has no room
    assign full   = q_full;
    assign accept = push && !q_full;
    assign emit   = accept && !dropping_reg && (last_byte || (held_count_reg == 2'd2));
    assign q_push = emit;

    // Assemble the group from held bytes and the new byte
    always_comb
    begin
        b0 = data_byte;
        b1 = 8'd0;
        b2 = 8'd0;
        unique case (held_count_reg)
            2'd0:
            begin
                b0 = data_byte;
            end
            2'd1:
            begin
                b0 = held_bytes_reg[15:8];
                b1 = data_byte;
            end
            default:
            begin
                b0 = held_bytes_reg[15:8];
                b1 = held_bytes_reg[7:0];
                b2 = data_byte;
            end
        endcase
    end

    // Count characters and test against the limit
    assign cw_sum = chars_written_reg + 21'd4;
    assign ovf    = ({1'b0, cw_sum} + 22'd4) > {2'b00, limit_reg};

    // Encode the quartet
    always_comb
    begin
        q_data.chars[0] = b64se_char(b0[7:2]);
        q_data.chars[1] = b64se_char({b0[1:0], b1[7:4]});
        q_data.chars[2] = (held_count_reg == 2'd0) ? PAD_CHAR
                                                   : b64se_char({b1[3:0], b2[7:6]});
        q_data.chars[3] = (held_count_reg != 2'd2) ? PAD_CHAR : b64se_char(b2[5:0]);
        q_data.msg_end  = last_byte || ovf;
        q_data.ovf      = ovf;
    end

    // Next message state
    always_comb
    begin
        held_bytes_next    = held_bytes_reg;
        held_count_next    = held_count_reg;
        chars_written_next = chars_written_reg;
        dropping_next      = dropping_reg;
        if (accept)
        begin
            priority if (dropping_reg)
            begin
                if (last_byte)
                begin
                    held_bytes_next    = 16'd0;
                    held_count_next    = 2'd0;
                    chars_written_next = 21'd0;
                    dropping_next      = 1'b0;
                end
            end
            else if (!emit)
            begin
                if (held_count_reg == 2'd0)
                    held_bytes_next = {data_byte, 8'd0};
                else
                    held_bytes_next = {held_bytes_reg[15:8], data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
            else
            begin
                held_bytes_next = 16'd0;
                held_count_next = 2'd0;
                if (last_byte)
                begin
                    chars_written_next = 21'd0;
                    dropping_next      = 1'b0;
                end
                else
                begin
                    chars_written_next = cw_sum;
                    dropping_next      = ovf;
                end
            end
        end
    end

    // Hold message state and the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg         <= LIMIT_RESET;
            held_bytes_reg    <= 16'd0;
            held_count_reg    <= 2'd0;
            chars_written_reg <= 21'd0;
            dropping_reg      <= 1'b0;
        end
        else
        begin
            if (output_limit_we)
                limit_reg <= output_limit_wdata;
            held_bytes_reg    <= held_bytes_next;
            held_count_reg    <= held_count_next;
            chars_written_reg <= chars_written_next;
            dropping_reg      <= dropping_next;
        end
    end

`ifndef SYNTH
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held byte count out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=>
            (held_count_reg == 2'd0) && (chars_written_reg == 21'd0) && !dropping_reg)
        else $error("message state not restarted after last byte");

    a_no_emit_dropping: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> !q_push)
        else $error("quartet emitted while dropping");
`endif

endmodule

// ===== src/b64se_fifo.sv =====
module b64se_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  b64se_pkg::b64se_quartet_t wr_data,
    output logic                      full,
    input  logic                      rd_en,
    output b64se_pkg::b64se_quartet_t rd_data,
    output logic                      valid
);
    import b64se_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    b64se_quartet_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_wr;
    logic do_rd;

    assign full    = (count_reg == CNT_MAX);
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem[rd_ptr_reg];

    // Store an entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("write into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> valid)
        else $error("read from empty queue");
`endif

endmodule

// ===== src/b64se_back.sv =====
module b64se_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  b64se_pkg::b64se_quartet_t q_data,
    input  logic                      q_valid,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                out_char,
    output logic                      run_last,
    output logic                      message_end,
    output logic                      overflow
);
    import b64se_pkg::*;

    b64se_quartet_t cur_reg;
    logic           busy_reg;
    logic [1:0]     idx_reg;
    logic           take;
    logic           at_end;

    assign take   = pop && busy_reg;
    assign at_end = (idx_reg == LAST_SLOT);
    assign q_pop  = q_valid && (!busy_reg || (take && at_end));

    // Present the current character
    assign empty       = !busy_reg;
    assign out_char    = cur_reg.chars[idx_reg];
    assign run_last    = at_end;
    assign message_end = at_end && cur_reg.msg_end;
    assign overflow    = cur_reg.ovf;

    // Load a quartet
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    // Step through the four characters, load when idle or on the last transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (take)
                idx_reg <= idx_reg + 2'd1;
            if (q_pop)
                busy_reg <= 1'b1;
            else if (take && at_end)
                busy_reg <= 1'b0;
        end
    end

`ifndef SYNTH
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (idx_reg == 2'd0))
        else $error("slot index not at start while idle");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !at_end) |=> busy_reg && (idx_reg == $past(idx_reg) + 2'd1))
        else $error("character step lost");

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("load from empty queue");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import b64se_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned PHASE_BYTES   = 30;

    // One character as it leaves the block
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
        logic       ovf;
    } b64_char_t;

    // Encoder image plus the characters it still owes
    class char_scoreboard;
        logic [19:0] limit;
        logic [15:0] held;
        logic [1:0]  held_n;
        logic [20:0] written;
        bit          dropping;
        b64_char_t   owed_chars[$];
        int unsigned failures;
        string       alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            limit    = LIMIT_RESET;
            failures = 0;
            restart();
        endfunction

        function void restart();
            held     = '0;
            held_n   = '0;
            written  = '0;
            dropping = 1'b0;
        endfunction

        function void set_limit(logic [19:0] value);
            limit = value;
        endfunction

        function int unsigned pending();
            return owed_chars.size();
        endfunction

        // Note one accepted byte; return 1 unless the byte fell into a dropped tail
        function bit take_byte(logic [7:0] b, logic last);
            logic [7:0]  b0, b1, b2;
            logic [5:0]  code [4];
            logic [7:0]  chars [4];
            int unsigned parts;
            bit          ovf;
            b64_char_t   c;
            if (dropping)
            begin
                if (last)
                    restart();
                return 1'b0;
            end
            // Hold the first two bytes of a group
            if (held_n < 2'd2 && !last)
            begin
                if (held_n == 2'd0)
                    held = {b, 8'h00};
                else
                    held[7:0] = b;
                held_n++;
                return 1'b1;
            end
            parts = held_n + 1;
            case (held_n)
                2'd0:
                begin
                    b0 = b;
                    b1 = 8'h00;
                    b2 = 8'h00;
                end
                2'd1:
                begin
                    b0 = held[15:8];
                    b1 = b;
                    b2 = 8'h00;
                end
                default:
                begin
                    b0 = held[15:8];
                    b1 = held[7:0];
                    b2 = b;
                end
            endcase
            code[0] = b0[7:2];
            code[1] = {b0[1:0], b1[7:4]};
            code[2] = {b1[3:0], b2[7:6]};
            code[3] = b2[5:0];
            for (int k = 0; k < 4; k++)
                chars[k] = alphabet[int'(code[k])];
            // Pad a short final group
            if (parts < 3)
                chars[3] = PAD_CHAR;
            if (parts < 2)
                chars[2] = PAD_CHAR;
            written = written + 21'd4;
            ovf = (int'(written) + 4) > int'(limit);
            for (int k = 0; k < 4; k++)
            begin
                c.ch       = chars[k];
                c.run_last = (k == 3);
                c.msg_end  = (k == 3) && (last || ovf);
                c.ovf      = ovf;
                owed_chars.push_back(c);
            end
            held   = '0;
            held_n = '0;
            if (last)
                restart();
            else if (ovf)
                dropping = 1'b1;
            return 1'b1;
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            if (failures < MAX_REPORTS)
                $error("%s mismatch: expected %h, actual %h", field, want, got);
        endfunction

        // Compare one transferred character with the oldest one owed
        function void check_char(b64_char_t got);
            b64_char_t want;
            bit        bad;
            if (owed_chars.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                    $error("character %h transferred with nothing owed", got.ch);
                failures++;
                return;
            end
            want = owed_chars.pop_front();
            bad  = 1'b0;
            if (got.ch !== want.ch)
            begin
                report("out_char", want.ch, got.ch);
                bad = 1'b1;
            end
            if (got.run_last !== want.run_last)
            begin
                report("run_last", 8'(want.run_last), 8'(got.run_last));
                bad = 1'b1;
            end
            if (got.msg_end !== want.msg_end)
            begin
                report("message_end", 8'(want.msg_end), 8'(got.msg_end));
                bad = 1'b1;
            end
            if (got.ovf !== want.ovf)
            begin
                report("overflow", 8'(want.ovf), 8'(got.ovf));
                bad = 1'b1;
            end
            if (bad)
                failures++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  out_char;
    logic        run_last;
    logic        message_end;
    logic        overflow;
    logic        output_limit_we;
    logic [19:0] output_limit_wdata;

    char_scoreboard sb;
    int unsigned    live_bytes;
    int             send_burst;
    int             recv_burst;

    base64_stream_encoder_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .empty              (empty),
        .pop                (pop),
        .out_char           (out_char),
        .run_last           (run_last),
        .message_end        (message_end),
        .overflow           (overflow),
        .output_limit_we    (output_limit_we),
        .output_limit_wdata (output_limit_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Draw an idle gap; now and then start a run with no gaps
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(10, 30);
        return $urandom_range(0, 3);
    endfunction

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = draw_gap(send_burst);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do @(posedge clk); while (full);
        if (sb.take_byte(b, l))
            live_bytes++;
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Stop sending, wait for every owed character, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [19:0] value);
        @(negedge clk);
        output_limit_we    <= 1'b1;
        output_limit_wdata <= value;
        @(negedge clk);
        output_limit_we    <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic random_phase(input logic [19:0] value);
        int unsigned start;
        int          len;
        drain();
        write_limit(value);
        start = live_bytes;
        while (live_bytes - start < PHASE_BYTES)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            send_message(len);
        end
    endtask

    // Receiver: pop with random gaps and check every transfer
    initial
    begin
        b64_char_t got;
        int        gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_burst);
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got = {out_char, run_last, message_end, overflow};
            sb.check_char(got);
        end
    end

    // Stimulus
    initial
    begin
        sb                 = new();
        live_bytes         = 0;
        send_burst         = 0;
        recv_burst         = 0;
        rst_n              = 1'b0;
        push               = 1'b0;
        data_byte          = 8'h00;
        last_byte          = 1'b0;
        pop                = 1'b0;
        output_limit_we    = 1'b0;
        output_limit_wdata = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit: each group length, zero bytes, '+' and '/'
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        // Hold off mid-message until every owed character is out
        drain();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);

        // Lowest limit: the first quartet overflows, the tail is dropped
        drain();
        write_limit(20'd4);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h45, 1'b1);
        send_byte(8'h7F, 1'b1);

        // Second quartet overflows; the last byte is dropped and restarts
        drain();
        write_limit(20'd8);
        for (int i = 1; i <= 7; i++)
            send_byte(8'(i), i == 7);

        // Random messages under several limits
        random_phase(20'd12);
        random_phase(LIMIT_RESET);
        random_phase(20'd4);
        repeat (4) random_phase(20'($urandom_range(4, 100)));
        random_phase(20'($urandom_range(4, 20'hFFFFF)));
        random_phase(20'($urandom_range(4, 100)));

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("base64_stream_encoder_top verification clean");
        else
            $display("base64_stream_encoder_top verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("base64_stream_encoder_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/b64se_pkg.sv
src/b64se_front.sv
src/b64se_fifo.sv
src/b64se_back.sv
src/base64_stream_encoder_top.sv
tb/tb_top.sv
